>>> src/wwqc_pkg.sv
package wwqc_pkg;

   localparam int unsigned DIV_STEPS = 4;
   localparam int unsigned CNT_W = $clog2(DIV_STEPS);
   localparam int unsigned REM_W = 16;
   localparam int unsigned HELD_W = 11;

   localparam logic [3:0] MAX_WIPES_RESET = 4'd3;
   localparam logic [15:0] WIPE_TIME_RESET = 16'd1500;
   localparam logic [31:0] WIPE_START_RESET = 32'd1;

   localparam logic CSR_MAX_WIPES = 1'b0;
   localparam logic CSR_WIPE_TIME = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BUTTON,
      S_DIV,
      S_COMMIT,
      S_QUEUE,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic button;
      logic div_start;
      logic div_step;
      logic div_commit;
      logic queue;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_needed;
   } status_type;

endpackage

>>> src/wwqc_req_if.sv
interface wwqc_req_if;
   logic valid;
   logic ready;
   logic full_button;
   logic hold_button;
   logic [31:0] now_ms;

   modport source (output valid, output full_button, output hold_button, output now_ms,
                   input ready);
   modport sink (input valid, input full_button, input hold_button, input now_ms,
                 output ready);
endinterface

>>> src/wwqc_rsp_if.sv
interface wwqc_rsp_if;
   logic valid;
   logic ready;
   logic motor_on;
   logic [3:0] wipes_pending;
   logic wipe_done;

   modport source (output valid, output motor_on, output wipes_pending, output wipe_done,
                   input ready);
   modport sink (input valid, input motor_on, input wipes_pending, input wipe_done,
                 output ready);
endinterface

>>> src/wwqc_datapath.sv
module wwqc_datapath #(
   parameter int unsigned HOLD_PERIOD_MS = 1500
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wwqc_pkg::cmd_type    cmd,
   output wwqc_pkg::status_type sts,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic                 in_full,
   input  logic                 in_hold,
   input  logic [31:0]          in_now,
   output logic                 out_motor_on,
   output logic [3:0]           out_wipes_pending,
   output logic                 out_wipe_done
);

   localparam logic [wwqc_pkg::REM_W:0] PERIOD = (wwqc_pkg::REM_W + 1)'(HOLD_PERIOD_MS);
   localparam logic [63:0] RECIP = 64'h2_0000_0000 / 64'(HOLD_PERIOD_MS);
   localparam logic [16:0] RECIP_LO = RECIP[16:0];
   localparam logic [16:0] RECIP_HI = RECIP[33:17];

   logic [3:0]  max_wipes_ff, max_wipes_in;
   logic [15:0] wipe_time_ff, wipe_time_in;

   logic        full_ff;
   logic        hold_ff;
   logic [31:0] now_ff;

   logic        full_latched_ff, full_latched_in;
   logic        hold_latched_ff, hold_latched_in;
   logic        moving_ff, moving_in;
   logic [3:0]  pending_ff, pending_in;
   logic [31:0] hold_start_ff, hold_start_in;
   logic [wwqc_pkg::HELD_W-1:0] held_rem_ff, held_rem_in;
   logic [31:0] wipe_start_ff, wipe_start_in;
   logic        done_ff, done_in;

   logic [32:0] dividend_ff, dividend_in;
   logic [49:0] prod_lo_ff, prod_lo_in;
   logic [49:0] prod_hi_ff, prod_hi_in;
   logic [32:0] quot_ff, quot_in;
   logic [32:0] qp_ff, qp_in;
   logic [wwqc_pkg::REM_W-1:0] rem_ff, rem_in;

   logic        motor_ff;
   logic [3:0]  pending_out_ff;
   logic        done_out_ff;

   logic        full_rise, full_fall, hold_rise, hold_fall;
   logic [66:0] quot_sum;
   logic [48:0] qp_full;
   logic [32:0] diff;
   logic [31:0] start_adj;
   logic [31:0] elapsed;

   always_comb begin
      full_rise = full_ff & ~full_latched_ff;
      full_fall = ~full_ff & full_latched_ff;
      hold_rise = ~full_rise & ~full_fall & hold_ff & ~hold_latched_ff;
      hold_fall = ~full_rise & ~full_fall & ~hold_ff & hold_latched_ff;
      sts.div_needed = hold_fall & (hold_start_ff != 32'd0);
      quot_sum = {prod_hi_ff, 17'd0} + {17'd0, prod_lo_ff};
      qp_full = {16'd0, quot_ff} * {33'd0, PERIOD[15:0]};
      diff = dividend_ff - qp_ff;
      start_adj = wipe_start_ff - {21'd0, held_rem_ff};
      elapsed = now_ff - start_adj;
   end

   always_comb begin
      max_wipes_in = max_wipes_ff;
      wipe_time_in = wipe_time_ff;
      if (csr_we) begin
         case (csr_index)
            wwqc_pkg::CSR_MAX_WIPES: max_wipes_in = csr_wdata[3:0];
            wwqc_pkg::CSR_WIPE_TIME: wipe_time_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      full_latched_in = full_latched_ff;
      hold_latched_in = hold_latched_ff;
      moving_in = moving_ff;
      pending_in = pending_ff;
      hold_start_in = hold_start_ff;
      held_rem_in = held_rem_ff;
      wipe_start_in = wipe_start_ff;
      done_in = done_ff;
      dividend_in = dividend_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      quot_in = quot_ff;
      qp_in = qp_ff;
      rem_in = rem_ff;

      if (cmd.button) begin
         if (full_rise) begin
            full_latched_in = 1'b1;
         end else if (full_fall) begin
            full_latched_in = 1'b0;
            if (pending_ff < max_wipes_ff) begin
               pending_in = pending_ff + 4'd1;
            end
         end else if (hold_rise) begin
            hold_latched_in = 1'b1;
            if (!moving_ff) begin
               moving_in = 1'b1;
               hold_start_in = now_ff;
            end
         end else if (hold_fall) begin
            hold_latched_in = 1'b0;
            if (hold_start_ff != 32'd0) begin
               moving_in = 1'b0;
            end
         end
      end

      if (cmd.div_start) begin
         dividend_in = {22'd0, held_rem_ff} + {1'b0, now_ff - hold_start_ff};
      end

      if (cmd.div_step) begin
         prod_lo_in = {17'd0, dividend_ff} * {33'd0, RECIP_LO};
         prod_hi_in = {17'd0, dividend_ff} * {33'd0, RECIP_HI};
         quot_in = quot_sum[65:33];
         qp_in = qp_full[32:0];
         if (diff[wwqc_pkg::REM_W:0] >= PERIOD) begin
            rem_in = wwqc_pkg::REM_W'(diff[wwqc_pkg::REM_W:0] - PERIOD);
         end else begin
            rem_in = diff[wwqc_pkg::REM_W-1:0];
         end
      end

      if (cmd.div_commit) begin
         held_rem_in = rem_ff[wwqc_pkg::HELD_W-1:0];
      end

      if (cmd.queue) begin
         done_in = 1'b0;
         if (!hold_latched_ff && (pending_ff != 4'd0)) begin
            if (!moving_ff) begin
               wipe_start_in = now_ff;
               moving_in = 1'b1;
            end else begin
               wipe_start_in = start_adj;
               held_rem_in = '0;
               if (elapsed >= {16'd0, wipe_time_ff}) begin
                  moving_in = 1'b0;
                  pending_in = pending_ff - 4'd1;
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wipes_ff <= wwqc_pkg::MAX_WIPES_RESET;
         wipe_time_ff <= wwqc_pkg::WIPE_TIME_RESET;
         full_latched_ff <= 1'b0;
         hold_latched_ff <= 1'b0;
         moving_ff <= 1'b0;
         pending_ff <= 4'd0;
         hold_start_ff <= 32'd0;
         held_rem_ff <= '0;
         wipe_start_ff <= wwqc_pkg::WIPE_START_RESET;
         done_ff <= 1'b0;
      end else begin
         max_wipes_ff <= max_wipes_in;
         wipe_time_ff <= wipe_time_in;
         full_latched_ff <= full_latched_in;
         hold_latched_ff <= hold_latched_in;
         moving_ff <= moving_in;
         pending_ff <= pending_in;
         hold_start_ff <= hold_start_in;
         held_rem_ff <= held_rem_in;
         wipe_start_ff <= wipe_start_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      quot_ff <= quot_in;
      qp_ff <= qp_in;
      rem_ff <= rem_in;
      if (cmd.capture) begin
         full_ff <= in_full;
         hold_ff <= in_hold;
         now_ff <= in_now;
      end
      if (cmd.emit) begin
         motor_ff <= moving_ff;
         pending_out_ff <= pending_ff;
         done_out_ff <= done_ff;
      end
   end

   assign out_motor_on = motor_ff;
   assign out_wipes_pending = pending_out_ff;
   assign out_wipe_done = done_out_ff;

endmodule

>>> src/wwqc_controller.sv
module wwqc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wwqc_pkg::status_type sts,
   output wwqc_pkg::cmd_type    cmd
);

   wwqc_pkg::state_type state_ff, state_in;
   logic [wwqc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wwqc_pkg::S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         wwqc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = wwqc_pkg::S_BUTTON;
            end
         end
         wwqc_pkg::S_BUTTON: begin
            cmd.button = 1'b1;
            if (sts.div_needed) begin
               cmd.div_start = 1'b1;
               cnt_in = '0;
               state_in = wwqc_pkg::S_DIV;
            end else begin
               state_in = wwqc_pkg::S_QUEUE;
            end
         end
         wwqc_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == wwqc_pkg::CNT_W'(wwqc_pkg::DIV_STEPS - 1)) begin
               state_in = wwqc_pkg::S_COMMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         wwqc_pkg::S_COMMIT: begin
            cmd.div_commit = 1'b1;
            state_in = wwqc_pkg::S_QUEUE;
         end
         wwqc_pkg::S_QUEUE: begin
            cmd.queue = 1'b1;
            state_in = wwqc_pkg::S_EMIT;
         end
         wwqc_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = wwqc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wwqc_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/wiper_wipe_queue_controller_top.sv
// Wiper queue controller: each request word is one button poll with a millisecond timestamp,
// and each poll yields exactly one response word with the motor drive, the pending wipe count
// and a pulse for a wipe that finished. A poll passes the button, queue and emit states to
// idle; a hold-button release adds the divide and commit states to fold the held time into
// the remainder, reduced modulo the hold period by a four-step reciprocal multiplication.
// A finished word waits in the output register while the next request is taken; the user must
// send configuration writes via the csr port only while no poll is in flight (not enforced).
module wiper_wipe_queue_controller_top #(
   parameter int unsigned HOLD_PERIOD_MS = 1500
) (
   input  logic        clock,
   input  logic        reset,
   wwqc_req_if.sink    req_chan,
   wwqc_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   wwqc_pkg::cmd_type    cmd;
   wwqc_pkg::status_type sts;

   wwqc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wwqc_datapath #(
      .HOLD_PERIOD_MS (HOLD_PERIOD_MS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .in_full           (req_chan.full_button),
      .in_hold           (req_chan.hold_button),
      .in_now            (req_chan.now_ms),
      .out_motor_on      (rsp_chan.motor_on),
      .out_wipes_pending (rsp_chan.wipes_pending),
      .out_wipe_done     (rsp_chan.wipe_done)
   );

endmodule
